### rtl/core/sha1_pkg.sv
// sha1_pkg: shared types and constants of the sha-1 digest engine
// depends on nothing
`default_nettype none
package sha1_pkg;
  localparam int QueueDepth = 4;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hefcdab89;
  localparam logic [31:0] H2 = 32'h98badcfe;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hc3d2e1f0;
  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;
  localparam logic [7:0]  PadByte = 8'h80;

  // one classified request passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } sha1_req_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction
endpackage
`default_nettype wire

### rtl/core/sha1_queue.sv
// sha1_queue: small request queue between front and back
// depends on sha1_pkg
`default_nettype none
module sha1_queue #(
  parameter int Depth = sha1_pkg::QueueDepth
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  sha1_pkg::sha1_req_t   in_req,
  output logic                  out_valid,
  input  wire                   out_ready,
  output sha1_pkg::sha1_req_t   out_req
);
  import sha1_pkg::*;
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  sha1_req_t      slots [Depth];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [AW:0]    count;
  logic           push, pop;

  assign in_ready  = (count != (AW+1)'(Depth));
  assign out_valid = (count != '0);
  assign out_req   = slots[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_req;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(Depth-1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(Depth-1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

### rtl/core/sha1_front.sv
// sha1_front: accepts input requests, drops empty ones, registers them
// depends on sha1_pkg
`default_nettype none
module sha1_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  valid,
  output logic                 ready,
  input  wire [7:0]            msg_byte,
  input  wire                  byte_present,
  input  wire                  end_of_message,
  output logic                 req_valid,
  input  wire                  req_ready,
  output sha1_pkg::sha1_req_t  req
);
  import sha1_pkg::*;
  logic useful;

  assign ready  = !req_valid || req_ready;
  assign useful = byte_present || end_of_message;

  always_ff @(posedge clk) begin
    if (valid && ready) begin
      req.data    <= msg_byte;
      req.present <= byte_present;
      req.last    <= end_of_message;
    end
    if (rst) req_valid <= 1'b0;
    else if (ready) req_valid <= valid && useful;
  end
endmodule
`default_nettype wire

### rtl/core/sha1_back.sv
// sha1_back: block collection, padding, 80-round compression, digest output
// depends on sha1_pkg
`default_nettype none
module sha1_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  req_valid,
  output logic                 req_ready,
  input  sha1_pkg::sha1_req_t  req,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic [31:0]          digest_word,
  output logic [2:0]           word_number,
  output logic                 final_word
);
  import sha1_pkg::*;

  typedef enum logic [5:0] {
    ST_COLLECT = 6'b000001,
    ST_ROUND   = 6'b000010,
    ST_PAD     = 6'b000100,
    ST_LEN     = 6'b001000,
    ST_EMIT    = 6'b010000,
    ST_WAIT    = 6'b100000
  } state_t;

  state_t       state;
  logic [31:0]  w [16];       // window: bytes shift in, then schedule
  logic [31:0]  h [5];
  logic [31:0]  a, b, c, d, e;
  logic [60:0]  byte_total;
  logic [5:0]   fill;         // bytes in current block
  logic [6:0]   round;
  logic         finishing;    // message end seen: padding pending or under way
  logic         len_done;     // length placed in the final block
  logic         pad_done;     // 0x80 marker already placed
  logic [2:0]   emit_idx;

  logic [31:0]  wt, f, k, tmp, wnew;
  logic [63:0]  bits;

  assign bits = {byte_total, 3'b000};
  assign req_ready = (state == ST_COLLECT);

  assign wnew = rotl(w[13] ^ w[8] ^ w[2] ^ w[0], 1);
  assign wt   = (round < 7'd16) ? w[0] : wnew;

  always_comb begin
    if (round < 7'd20) begin
      f = (b & c) | (~b & d); k = K0;
    end else if (round < 7'd40) begin
      f = b ^ c ^ d; k = K1;
    end else if (round < 7'd60) begin
      f = (b & c) | (b & d) | (c & d); k = K2;
    end else begin
      f = b ^ c ^ d; k = K3;
    end
  end
  assign tmp = rotl(a, 5) + f + e + k + wt;

  assign digest_word = h[emit_idx];
  assign word_number = emit_idx;
  assign final_word  = (emit_idx == 3'd4);
  assign out_valid   = (state == ST_EMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
      h[0] <= H0; h[1] <= H1; h[2] <= H2; h[3] <= H3; h[4] <= H4;
      byte_total <= '0;
      fill <= '0;
      round <= '0;
      finishing <= 1'b0;
      len_done <= 1'b0;
      pad_done <= 1'b0;
      emit_idx <= '0;
    end else begin
      case (state)
        ST_COLLECT: begin
          if (req_valid) begin
            if (req.present) begin
              w[15] <= {w[15][23:0], req.data};
              for (int i = 0; i < 15; i++)
                if (fill[5:2] == 4'(i)) w[i] <= {w[i][23:0], req.data};
              byte_total <= byte_total + 61'd1;
              fill <= fill + 6'd1;
            end
            finishing <= req.last;
            if (req.present && fill == 6'd63) begin
              state <= ST_ROUND;
            end else if (req.last) begin
              state <= ST_PAD;
            end
            a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
            round <= '0;
          end
        end
        ST_PAD: begin
          // one padding byte per cycle: 0x80 then zeros up to the length or the block end
          for (int i = 0; i < 16; i++)
            if (fill[5:2] == 4'(i))
              w[i] <= {w[i][23:0], pad_done ? 8'h00 : PadByte};
          pad_done <= 1'b1;
          fill <= fill + 6'd1;
          if (fill == 6'd63) begin
            state <= ST_ROUND;
          end else if (fill == 6'd55) begin
            state <= ST_LEN;
          end
          a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
          round <= '0;
        end
        ST_LEN: begin
          w[14] <= bits[63:32];
          w[15] <= bits[31:0];
          len_done <= 1'b1;
          fill <= '0;
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= wt;
          e <= d; d <= c; c <= rotl(b, 30); b <= a; a <= tmp;
          round <= round + 7'd1;
          if (round == 7'd79) begin
            h[0] <= h[0] + tmp; h[1] <= h[1] + a; h[2] <= h[2] + rotl(b, 30);
            h[3] <= h[3] + c;   h[4] <= h[4] + d;
            fill <= '0;
            if (len_done) begin
              state <= ST_EMIT;
              emit_idx <= '0;
            end else if (finishing) begin
              state <= ST_WAIT;
            end else begin
              state <= ST_COLLECT;
            end
          end
        end
        ST_WAIT: begin
          // after a full block at message end, or a padding block with no room for the length: pad a fresh block
          state <= ST_PAD;
          a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
          round <= '0;
        end
        ST_EMIT: begin
          if (out_ready) begin
            if (emit_idx == 3'd4) begin
              h[0] <= H0; h[1] <= H1; h[2] <= H2; h[3] <= H3; h[4] <= H4;
              byte_total <= '0;
              fill <= '0;
              finishing <= 1'b0;
              len_done <= 1'b0;
              pad_done <= 1'b0;
              emit_idx <= '0;
              state <= ST_COLLECT;
            end else begin
              emit_idx <= emit_idx + 3'd1;
            end
          end
        end
        default: state <= ST_COLLECT;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/core/sha1_message_digest.sv
// sha1_message_digest: streaming sha-1 engine, top level
// depends on sha1_pkg, sha1_front, sha1_queue, sha1_back
// one byte request per cycle is collected into the window while the back end is
// in its collect state; each 64-byte block then runs 80 rounds in the single round
// unit; a final request adds the padding bytes (plus a restart when the length
// spills into a second block), the length words, the rounds of one or two blocks
// and five digest words, one per cycle while the receiver is ready
// reset restores the initial chaining words and a zero byte count
`default_nettype none
module sha1_message_digest #(
  parameter int QueueDepth = sha1_pkg::QueueDepth
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  msg_byte,
  input  wire         byte_present,
  input  wire         end_of_message,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_number,
  output logic        final_word
);
  import sha1_pkg::*;

  // front to queue and queue to back
  sha1_req_t fq_req, qb_req;
  logic      fq_valid, fq_ready, qb_valid, qb_ready;

  sha1_front u_front (
    .clk, .rst,
    .valid(in_valid), .ready(in_ready),
    .msg_byte, .byte_present, .end_of_message,
    .req_valid(fq_valid), .req_ready(fq_ready), .req(fq_req)
  );

  // decouples byte intake from the compression rounds
  sha1_queue #(.Depth(QueueDepth)) u_queue (
    .clk, .rst,
    .in_valid(fq_valid), .in_ready(fq_ready), .in_req(fq_req),
    .out_valid(qb_valid), .out_ready(qb_ready), .out_req(qb_req)
  );

  sha1_back u_back (
    .clk, .rst,
    .req_valid(qb_valid), .req_ready(qb_ready), .req(qb_req),
    .out_valid, .out_ready, .digest_word, .word_number, .final_word
  );
endmodule
`default_nettype wire

### test/sha1_digest_checker.sv
// sha1_digest_checker: watches the request and digest channels of sha1_message_digest,
// predicts each digest word with its own sha-1 model and counts mismatches
// depends on nothing outside this file
`default_nettype none
module sha1_digest_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  input  wire         in_ready,
  input  wire  [7:0]  msg_byte,
  input  wire         byte_present,
  input  wire         end_of_message,
  input  wire         out_valid,
  input  wire         out_ready,
  input  wire  [31:0] digest_word,
  input  wire  [2:0]  word_number,
  input  wire         final_word,
  output int          fail_count,
  output int          pending_words
);
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] InitChain [5] = '{32'h67452301, 32'hefcdab89, 32'h98badcfe,
                                            32'h10325476, 32'hc3d2e1f0};

  logic [31:0]  chain [5];
  logic [7:0]   block_bytes [64];
  logic [60:0]  bytes_taken;
  digest_word_t digest_queue [$];

  function automatic logic [31:0] rol(input logic [31:0] v, input int n);
    rol = (v << n) | (v >> (32 - n));
  endfunction

  task automatic run_rounds();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, sum;
    for (int t = 0; t < 16; t++)
      w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
    for (int t = 0; t < 80; t++) begin
      if (t >= 16)
        w[t%16] = rol(w[(t-3)%16] ^ w[(t-8)%16] ^ w[(t-14)%16] ^ w[t%16], 1);
      if (t < 20) begin
        f = (b & c) | (~b & d); k = 32'h5a827999;
      end else if (t < 40) begin
        f = b ^ c ^ d; k = 32'h6ed9eba1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8f1bbcdc;
      end else begin
        f = b ^ c ^ d; k = 32'hca62c1d6;
      end
      sum = rol(a, 5) + f + e + k + w[t%16];
      e = d; d = c; c = rol(b, 30); b = a; a = sum;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
  endtask

  task automatic take_request(input logic [7:0] data, input logic present, input logic last);
    int pos;
    logic [63:0] bit_len;
    if (present) begin
      block_bytes[bytes_taken[5:0]] = data;
      bytes_taken = bytes_taken + 61'd1;
      if (bytes_taken[5:0] == 0) run_rounds();
    end
    if (last) begin
      pos = int'(bytes_taken[5:0]);
      bit_len = {bytes_taken, 3'b000};
      block_bytes[pos] = 8'h80;
      pos++;
      if (pos > 56) begin
        while (pos < 64) block_bytes[pos++] = 8'h00;
        run_rounds();
        pos = 0;
      end
      while (pos < 56) block_bytes[pos++] = 8'h00;
      for (int i = 0; i < 8; i++) block_bytes[56+i] = bit_len[8*(7-i) +: 8];
      run_rounds();
      for (int i = 0; i < 5; i++) digest_queue.push_back('{chain[i], 3'(i), i == 4});
      chain = InitChain;
      bytes_taken = '0;
    end
  endtask

  assign pending_words = digest_queue.size();

  always @(posedge clk) begin
    digest_word_t exp_word;
    if (rst) begin
      chain = InitChain;
      bytes_taken = '0;
      digest_queue.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) take_request(msg_byte, byte_present, end_of_message);
      if (out_valid && out_ready) begin
        if (digest_queue.size() == 0) begin
          $error("unexpected digest word %h", digest_word);
          fail_count++;
        end else begin
          exp_word = digest_queue.pop_front();
          if (digest_word !== exp_word.word) begin
            $error("digest_word expected %h actual %h", exp_word.word, digest_word);
            fail_count++;
          end
          if (word_number !== exp_word.index) begin
            $error("word_number expected %0d actual %0d", exp_word.index, word_number);
            fail_count++;
          end
          if (final_word !== exp_word.last) begin
            $error("final_word expected %0d actual %0d", exp_word.last, final_word);
            fail_count++;
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

### test/tb_sha1_message_digest.sv
// tb_sha1_message_digest: stimulus and verdict for the streaming sha-1 engine
// depends on sha1_pkg, sha1_message_digest and sha1_digest_checker
`default_nettype none
module tb_sha1_message_digest;
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  msg_byte = '0;
  logic        byte_present = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_ready = 1'b0;
  wire         in_ready, out_valid, final_word;
  wire  [31:0] digest_word;
  wire  [2:0]  word_number;
  int          fail_count, pending_words;
  int          cycle_count = 0;
  bit          no_idle = 1'b0;   // long stretch where neither side pauses
  bit          stimulus_done = 1'b0;

  always #5 clk = ~clk;

  sha1_message_digest u_dut (
    .clk, .rst, .in_valid, .in_ready, .msg_byte, .byte_present, .end_of_message,
    .out_valid, .out_ready, .digest_word, .word_number, .final_word
  );

  sha1_digest_checker u_checker (
    .clk, .rst, .in_valid, .in_ready, .msg_byte, .byte_present, .end_of_message,
    .out_valid, .out_ready, .digest_word, .word_number, .final_word,
    .fail_count, .pending_words
  );

  // receiver stalls at random, with a chance of 20 in 100, except during the no-idle stretch
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= no_idle || ($urandom_range(99) >= 20);
  end

  // timeout: gives up with a FAIL verdict if the run goes on too long
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 400000) begin
      $display("tb_sha1_message_digest: FAIL");
      $finish;
    end
  end

  // send one request; random gap first outside the no-idle stretch, then hold valid until accepted
  task automatic send_request(input logic [7:0] data, input logic present, input logic last);
    while (!no_idle && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    msg_byte <= data;
    byte_present <= present;
    end_of_message <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // message of n random bytes; the end mark rides on the last byte or alone
  task automatic send_message(input int n, input bit separate_end);
    for (int i = 0; i < n; i++)
      send_request(8'($urandom), 1'b1, (i == n - 1) && !separate_end);
    if (separate_end || n == 0) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: empty message, extreme byte values, idle requests
    send_request(8'hff, 1'b0, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'ha5, 1'b0, 1'b0);
    send_request(8'h5a, 1'b1, 1'b0);
    send_request(8'hc3, 1'b0, 1'b0);
    send_request(8'h3c, 1'b0, 1'b1);
    // pause until every digest word has come back
    wait_drained();
    // one long message: a full block, then 56 more bytes so the length
    // spills into a second padding block; the second half runs without pauses
    for (int i = 0; i < 64; i++) send_request(8'($urandom), 1'b1, 1'b0);
    no_idle = 1'b1;
    send_message(56, 1'b0);
    no_idle = 1'b0;
    // a few short random messages after the long one
    repeat (3) send_message($urandom_range(0, 4), 1'($urandom_range(1)));
    wait_drained();
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("tb_sha1_message_digest: PASS");
    else $display("tb_sha1_message_digest: FAIL");
    $finish;
  end
endmodule
`default_nettype wire

### sha1_message_digest.f
rtl/core/sha1_pkg.sv
rtl/core/sha1_queue.sv
rtl/core/sha1_front.sv
rtl/core/sha1_back.sv
rtl/core/sha1_message_digest.sv
test/sha1_digest_checker.sv
test/tb_sha1_message_digest.sv
